// File: design/wf_pkg.sv
// Shared types and constants for the waypoint follower.
// Holds operation codes, register indexes, the CORDIC arctangent table and the
// request struct for the CORDIC unit. No dependencies.
`default_nettype none

package wf_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SETPOS = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] REG_SPEED    = 3'd0;
  localparam logic [2:0] REG_ACCEPT   = 3'd1;
  localparam logic [2:0] REG_FLIP     = 3'd2;
  localparam logic [2:0] REG_COUNT    = 3'd3;
  localparam logic [2:0] REG_INTERVAL = 3'd4;

  localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;

  typedef struct packed {
    logic start;
    logic vec;   // 1: vectoring (atan2), 0: rotation (sin/cos)
  } cordic_req_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/wf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module wf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/wf_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring.
// Depends on wf_pkg (arctangent table, gain, request struct).
`default_nettype none

module wf_cordic
  import wf_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cordic_req_t        req_i,
  input  wire logic        [15:0] ang_i,
  input  wire logic signed [32:0] vx_i,
  input  wire logic signed [32:0] vz_i,
  output logic                    done_o,
  output logic signed      [31:0] sin_o,
  output logic signed      [31:0] cos_o,
  output logic             [31:0] angle_o
);

  localparam int CNTW = $clog2(CORDIC_STEPS);

  logic signed [35:0] x_q, y_q;
  logic signed [33:0] z_q;
  logic [CNTW-1:0]    cnt_q;
  logic               busy_q, vec_q, neg_q, zero_q;

  logic [31:0] a_rot, a_t;
  logic signed [35:0] xs, ys, neg_x, neg_y;
  logic signed [33:0] at;
  logic up;
  logic [4:0] sh;

  always_comb begin
    a_rot = {ang_i, 16'h0};
    a_t   = a_rot + 32'h4000_0000;
    sh    = 5'(cnt_q);
    xs    = x_q >>> sh;
    ys    = y_q >>> sh;
    at    = {2'b00, atan_lut(sh)};
    up    = vec_q ? (y_q <= 36'sd0) : (z_q >= 34'sd0);
    neg_x = -x_q;
    neg_y = -y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        vec_q  <= req_i.vec;
        if (req_i.vec) begin
          neg_q  <= 1'b0;
          zero_q <= (vx_i == 33'sd0) && (vz_i == 33'sd0);
          // start in the right half plane
          if (vz_i < 33'sd0) begin
            x_q <= -36'(vz_i);
            y_q <= -36'(vx_i);
            z_q <= 34'h0_8000_0000;
          end else begin
            x_q <= 36'(vz_i);
            y_q <= 36'(vx_i);
            z_q <= '0;
          end
        end else begin
          zero_q <= 1'b0;
          x_q    <= CORDIC_GAIN;
          y_q    <= '0;
          // fold the back half onto the front half
          if (a_t[31]) begin
            neg_q <= 1'b1;
            z_q   <= 34'(signed'(a_rot - 32'h8000_0000));
          end else begin
            neg_q <= 1'b0;
            z_q   <= 34'(signed'(a_rot));
          end
        end
      end else if (busy_q) begin
        if (up) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
        if (cnt_q == CNTW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign sin_o   = neg_q ? neg_y[31:0] : y_q[31:0];
  assign cos_o   = neg_q ? neg_x[31:0] : x_q[31:0];
  assign angle_o = zero_q ? 32'h0 : z_q[31:0];

endmodule

`default_nettype wire

// File: design/waypoint_follower_top.sv
// Waypoint follower top level: sequencer, state registers and output register.
// Depends on wf_pkg, wf_ram and wf_cordic.
//
// One transaction at a time. Load, set-position and no-op items go from accept
// straight to the output state. A tick that does not aim runs one rotation for
// sine and cosine; each aim adds a vectoring run, and a tick may aim on both
// occasions. The shared CORDIC unit does one micro-rotation a cycle. The
// finished result sits in an output register, so the next item is taken while
// it waits.
`default_nettype none

module waypoint_follower_top
  import wf_pkg::*;
#(
  parameter int MAX_WAYPOINTS = 16,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  output logic              s_tready_o,
  // tdata: slot[3:0], coord_x[35:4], coord_y[67:36], coord_z[99:68],
  //        delta_time[115:100], zero fill[119:116]
  input  wire logic [119:0] s_tdata_i,
  // tuser: operation[1:0]
  input  wire logic [1:0]   s_tuser_i,
  output logic              m_tvalid_o,
  input  wire logic         m_tready_i,
  // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], heading[111:96],
  //        target_index[115:112], reached[116], zero fill[119:117]
  output logic      [119:0] m_tdata_o,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [23:0]  cfg_wdata_i
);

  localparam int IW = $clog2(MAX_WAYPOINTS);
  localparam int CW = (IW + 1 > 5) ? IW + 1 : 5;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_ROTW, S_MULX, S_MULZ, S_MOVE, S_AIM1, S_VEC1,
    S_SQ, S_CMP, S_RD, S_AIM2, S_VEC2, S_DONE
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  state_e state_q;
  logic [23:0] speed_q, accept_q;
  logic        flip_q;
  logic [4:0]  count_q;
  logic [15:0] intv_q;
  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
  logic [15:0] yaw_q, delay_q;
  logic [IW-1:0] idx_q;
  logic aimed_q, reached_q, over_q;
  logic [1:0] k_q;
  logic [51:0] sum_q;
  logic [47:0] accsq_q;
  logic signed [56:0] prod_q;
  logic signed [26:0] mx_q;

  logic [1:0] op;
  logic [3:0] slot;
  logic signed [31:0] in_x, in_y, in_z;
  logic [15:0] dt;
  assign op   = s_tuser_i;
  assign slot = s_tdata_i[3:0];
  assign in_x = s_tdata_i[35:4];
  assign in_y = s_tdata_i[67:36];
  assign in_z = s_tdata_i[99:68];
  assign dt   = s_tdata_i[115:100];

  logic accept;
  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  // waypoint table
  logic [IW+3:0] slot_ext;
  logic          ram_we;
  logic [95:0]   wp;
  assign slot_ext = {{IW{1'b0}}, slot};
  assign ram_we   = accept && (op == OP_LOAD) && (32'(slot) < MAX_WAYPOINTS);

  wf_ram #(.WIDTH(96), .DEPTH(MAX_WAYPOINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_ext[IW-1:0]),
    .wdata_i ({in_z, in_y, in_x}),
    .raddr_i (idx_q),
    .rdata_o (wp)
  );

  logic signed [31:0] wp_x, wp_y, wp_z;
  assign wp_x = wp[31:0];
  assign wp_y = wp[63:32];
  assign wp_z = wp[95:64];

  // shared CORDIC
  cordic_req_t req;
  logic cdone;
  logic signed [31:0] csin, ccos;
  logic [31:0] cang;
  logic signed [32:0] vx, vz;
  assign vx = 33'(wp_x) - 33'(pos_x_q);
  assign vz = 33'(wp_z) - 33'(pos_z_q);

  always_comb begin
    req.start = (state_q == S_ROT) ||
                (state_q == S_AIM1 && !aimed_q) ||
                (state_q == S_AIM2 && delay_q >= intv_q);
    req.vec   = (state_q != S_ROT);
  end

  wf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .ang_i   (yaw_q),
    .vx_i    (vx),
    .vz_i    (vz),
    .done_o  (cdone),
    .sin_o   (csin),
    .cos_o   (ccos),
    .angle_o (cang)
  );

  // heading from the vector angle, rounded to 16 bits, turned half a circle when flipped
  logic [31:0] ang_rnd;
  logic [15:0] head_new;
  assign ang_rnd  = cang + 32'h0000_8000;
  assign head_new = flip_q ? (ang_rnd[31:16] + 16'h8000) : ang_rnd[31:16];

  // counts and indexes
  logic [CW-1:0] cnt_eff, idx_ext, idx_inc;
  assign cnt_eff = (CW'(count_q) > CW'(MAX_WAYPOINTS)) ? CW'(MAX_WAYPOINTS) : CW'(count_q);
  assign idx_ext = CW'(idx_q);
  assign idx_inc = idx_ext + 1'b1;

  logic [16:0] delay_sum;
  assign delay_sum = 17'(delay_q) + 17'(dt);

  // movement multiply and rounding
  logic signed [56:0] mul_in, prod_rnd;
  logic signed [26:0] m_rnd;
  logic signed [27:0] mz_f, mx_f;
  assign mul_in   = 57'(signed'({1'b0, speed_q})) *
                    57'((state_q == S_MULX) ? csin : ccos);
  assign prod_rnd = prod_q + 57'sd536870912;
  assign m_rnd    = prod_rnd[56:30];
  assign mz_f     = flip_q ? -28'(m_rnd) : 28'(m_rnd);
  assign mx_f     = flip_q ? -28'(mx_q) : 28'(mx_q);

  // squared distance, one axis per cycle, then the squared radius
  logic signed [32:0] dd;
  logic [32:0] dabs;
  logic [24:0] sq_op;
  logic [49:0] sq;
  always_comb begin
    unique case (k_q)
      2'd0:    dd = 33'(pos_x_q) - 33'(wp_x);
      2'd1:    dd = 33'(pos_y_q) - 33'(wp_y);
      default: dd = 33'(pos_z_q) - 33'(wp_z);
    endcase
    dabs  = dd[32] ? 33'(-dd) : 33'(dd);
    sq_op = (k_q == 2'd3) ? {1'b0, accept_q} : dabs[24:0];
    sq    = 50'(sq_op) * 50'(sq_op);
  end

  logic [IW+3:0] idx_out;
  assign idx_out = {4'b0, idx_q};

  logic out_free;
  assign out_free = !m_tvalid_o || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      speed_q    <= '0;
      accept_q   <= 24'd65536;
      flip_q     <= 1'b0;
      count_q    <= '0;
      intv_q     <= 16'd4096;
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      pos_z_q    <= '0;
      yaw_q      <= '0;
      idx_q      <= '0;
      aimed_q    <= 1'b0;
      delay_q    <= '0;
      reached_q  <= 1'b0;
      m_tvalid_o <= 1'b0;
      k_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_SPEED:    speed_q  <= cfg_wdata_i;
          REG_ACCEPT:   accept_q <= cfg_wdata_i;
          REG_FLIP:     flip_q   <= cfg_wdata_i[0];
          REG_COUNT:    count_q  <= cfg_wdata_i[4:0];
          REG_INTERVAL: intv_q   <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end

      // load a finished result, or drop the one taken by the sink
      if (state_q == S_DONE && out_free) begin
        m_tvalid_o <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_o <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            reached_q <= 1'b0;
            state_q   <= S_DONE;
            if (op == OP_SETPOS) begin
              pos_x_q <= in_x;
              pos_y_q <= in_y;
              pos_z_q <= in_z;
            end else if (op == OP_TICK && cnt_eff != '0) begin
              if (idx_ext >= cnt_eff) idx_q <= '0;
              delay_q <= delay_sum[16] ? 16'hFFFF : delay_sum[15:0];
              state_q <= S_ROT;
            end
          end
        end
        S_ROT:  state_q <= S_ROTW;
        S_ROTW: if (cdone) state_q <= S_MULX;
        S_MULX: begin
          prod_q  <= mul_in;
          state_q <= S_MULZ;
        end
        S_MULZ: begin
          mx_q    <= m_rnd;
          prod_q  <= mul_in;
          state_q <= S_MOVE;
        end
        S_MOVE: begin
          pos_x_q <= sat32(34'(pos_x_q) + 34'(mx_f));
          pos_z_q <= sat32(34'(pos_z_q) + 34'(mz_f));
          state_q <= S_AIM1;
        end
        S_AIM1: begin
          k_q    <= '0;
          sum_q  <= '0;
          over_q <= 1'b0;
          state_q <= aimed_q ? S_SQ : S_VEC1;
        end
        S_VEC1: begin
          if (cdone) begin
            yaw_q   <= head_new;
            aimed_q <= 1'b1;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (k_q == 2'd3) begin
            accsq_q <= sq[47:0];
            state_q <= S_CMP;
          end else begin
            sum_q  <= sum_q + 52'(sq);
            if (dabs[32:25] != '0) over_q <= 1'b1;
            k_q <= k_q + 1'b1;
          end
        end
        S_CMP: begin
          if (!over_q && sum_q <= 52'(accsq_q)) begin
            idx_q     <= (idx_inc >= cnt_eff) ? '0 : idx_inc[IW-1:0];
            aimed_q   <= 1'b0;
            reached_q <= 1'b1;
          end
          state_q <= S_RD;
        end
        // wait for the table read at the new index
        S_RD:   state_q <= S_AIM2;
        S_AIM2: state_q <= (delay_q >= intv_q) ? S_VEC2 : S_DONE;
        S_VEC2: begin
          if (cdone) begin
            yaw_q   <= head_new;
            delay_q <= '0;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata_o  <= {3'b0, reached_q, idx_out[3:0], yaw_q,
                           pos_z_q, pos_y_q, pos_x_q};
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/wf_checker.sv
// Port-level checker for the waypoint follower, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module wf_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_tvalid_i,
  input wire logic         s_tready_o,
  input wire logic         m_tvalid_o,
  input wire logic         m_tready_i,
  input wire logic [119:0] m_tdata_o
);

  // one transaction in flight: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input ready after accept");

  // a new result appears only as the sequencer leaves a busy state
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(!s_tready_o))
    else $error("result without work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("stalled result changed");

endmodule

bind waypoint_follower_top wf_checker u_wf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for waypoint_follower_top.
// Predicts every result in SystemVerilog, drives random stream traffic with idling.
// Depends on wf_pkg and the design sources.
`timescale 1ns / 1ps

module tb_top;
  import wf_pkg::*;

  localparam int TBL = 16;
  localparam int STEPS = 16;
  localparam longint GAIN = 652032874;
  localparam logic [1:0] OP_NONE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid_i = 1'b0;
  logic s_tready_o;
  logic [119:0] s_tdata_i = '0;
  logic [1:0] s_tuser_i = '0;
  logic m_tvalid_o;
  logic m_tready_i = 1'b0;
  logic [119:0] m_tdata_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = '0;
  logic [23:0] cfg_wdata_i = '0;

  waypoint_follower_top dut (.*);

  always #6 clk_i = ~clk_i;

  // laid out as on m_tdata_o, last member in the lowest bits
  typedef struct packed {
    logic hit;
    logic [3:0] idx;
    logic [15:0] hdg;
    logic [31:0] pz, py, px;
  } pose_t;

  // steering model state
  logic [23:0] m_speed, m_accept;
  logic m_flip;
  logic [4:0] m_count;
  logic [15:0] m_interval;
  logic signed [31:0] wp_tbl[TBL][3];
  logic signed [31:0] m_pos[3];
  logic [15:0] m_yaw, m_delay;
  logic [3:0] m_idx;
  logic m_aimed;

  pose_t pose_q[$];
  int errors = 0;
  int n_sent = 0, n_ticks = 0, n_hits = 0;
  bit idle_on = 1'b1;
  longint cycles = 0;

  function automatic longint atan_k(int i);
    return longint'(atan_lut(i[4:0]));
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic sin_cos(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] a;
    bit neg;
    longint x, y, z, nx, ny;
    a = {ang, 16'h0};
    neg = 0;
    x = GAIN; y = 0;
    if (((a + 32'h40000000) & 32'h80000000) != 0) begin
      a = a - 32'h80000000; neg = 1;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_k(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_k(i);
      end
      x = nx; y = ny;
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endtask

  function automatic logic [31:0] vec_angle(longint dz, longint dx);
    longint x, y, nx, ny;
    logic [31:0] z;
    x = dz; y = dx; z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_lut(i[4:0]);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_lut(i[4:0]);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  task automatic aim_at_target();
    logic [31:0] a;
    logic [15:0] h;
    a = vec_angle(longint'(wp_tbl[m_idx][2]) - m_pos[2],
                  longint'(wp_tbl[m_idx][0]) - m_pos[0]);
    h = 16'((a + 32'h8000) >> 16);
    if (m_flip) h = h + 16'h8000;
    m_yaw = h;
  endtask

  function automatic bit near_target();
    longint unsigned sum, acc, m;
    longint d;
    sum = 0;
    acc = m_accept;
    for (int k = 0; k < 3; k++) begin
      d = longint'(m_pos[k]) - wp_tbl[m_idx][k];
      m = d < 0 ? -d : d;
      if (m >= (64'd1 << 25)) return 0;
      sum += m * m;
    end
    return sum <= acc * acc;
  endfunction

  task automatic predict_pose(input logic [1:0] op, input logic [3:0] slot,
                              input logic [31:0] cx, cy, cz, input logic [15:0] dt);
    pose_t r;
    int cnt;
    longint s, c, mx, mz, d;
    bit hit;
    hit = 0;
    case (op)
      OP_LOAD: begin
        wp_tbl[slot][0] = cx; wp_tbl[slot][1] = cy; wp_tbl[slot][2] = cz;
      end
      OP_SETPOS: begin
        m_pos[0] = cx; m_pos[1] = cy; m_pos[2] = cz;
      end
      OP_TICK: begin
        cnt = m_count > TBL ? TBL : m_count;
        if (cnt != 0) begin
          if (m_idx >= cnt) m_idx = 0;
          d = longint'(m_delay) + dt;
          m_delay = d > 65535 ? 16'hFFFF : 16'(d);
          sin_cos(m_yaw, s, c);
          mx = (longint'(m_speed) * s + (64'sd1 << 29)) >>> 30;
          mz = (longint'(m_speed) * c + (64'sd1 << 29)) >>> 30;
          if (m_flip) begin
            mx = -mx; mz = -mz;
          end
          m_pos[0] = 32'(sat32(longint'(m_pos[0]) + mx));
          m_pos[2] = 32'(sat32(longint'(m_pos[2]) + mz));
          if (!m_aimed) begin
            aim_at_target(); m_aimed = 1;
          end
          if (near_target()) begin
            m_idx = (32'(m_idx) + 1 >= cnt) ? 4'd0 : m_idx + 4'd1;
            m_aimed = 0; hit = 1;
          end
          if (m_delay >= m_interval) begin
            aim_at_target(); m_delay = 0;
          end
        end
      end
      default: ;
    endcase
    r.px = m_pos[0]; r.py = m_pos[1]; r.pz = m_pos[2];
    r.hdg = m_yaw; r.idx = m_idx; r.hit = hit;
    if (hit) n_hits++;
    pose_q.push_back(r);
  endtask

  // when idling is on, sometimes hold valid low for a burst of idle cycles
  task automatic idle_gap();
    if (idle_on && $urandom_range(3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [3:0] slot,
                           input logic [31:0] cx, cy, cz, input logic [15:0] dt);
    idle_gap();
    s_tvalid_i <= 1'b1;
    s_tuser_i <= op;
    s_tdata_i <= {4'h0, dt, cz, cy, cx, slot};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    predict_pose(op, slot, cx, cy, cz, dt);
    if (op == OP_TICK) n_ticks++;
    n_sent++;
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we_i <= 1'b1; cfg_addr_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_SPEED: m_speed = val;
      REG_ACCEPT: m_accept = val;
      REG_FLIP: m_flip = val[0];
      REG_COUNT: m_count = val[4:0];
      REG_INTERVAL: m_interval = val[15:0];
      default: ;
    endcase
  endtask

  task automatic setup(input logic [23:0] spd, acc, input logic flp,
                       input logic [4:0] cnt, input logic [15:0] ivl);
    drain();
    write_reg(REG_SPEED, spd);
    write_reg(REG_ACCEPT, acc);
    write_reg(REG_FLIP, {23'h0, flp});
    write_reg(REG_COUNT, {19'h0, cnt});
    write_reg(REG_INTERVAL, {8'h0, ivl});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'(signed'($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  task automatic load_all(input int n);
    for (int i = 0; i < n; i++)
      send_item(OP_LOAD, i[3:0], rnd_coord(), rnd_coord(), rnd_coord(), 16'($urandom()));
  endtask

  task automatic test_directed();
    setup(24'h0, 24'h10000, 1'b0, 5'd0, 16'd4096);
    send_item(OP_TICK, 4'h0, 0, 0, 0, 16'hFFFF);      // zero count: nothing moves
    send_item(OP_NONE, 4'hF, 32'hFFFFFFFF, 0, 0, 0);
    send_item(OP_LOAD, 4'h0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
    send_item(OP_LOAD, 4'hF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
    for (int i = 1; i < 15; i++) send_item(OP_LOAD, i[3:0], 0, 0, 0, 0);
    setup(24'hFFFFFF, 24'hFFFFFF, 1'b1, 5'd31, 16'd0);  // count above table
    send_item(OP_SETPOS, 4'h0, 32'h80000000, 32'hFFFFFFFF, 32'h80000000, 0);
    send_item(OP_TICK, 4'h0, 0, 0, 0, 16'hFFFF);
    send_item(OP_TICK, 4'h0, 0, 0, 0, 16'h0);
    send_item(OP_SETPOS, 4'h0, 0, 0, 0, 0);             // position back to the origin
    send_item(OP_TICK, 4'h0, 0, 0, 0, 16'h1);
    setup(24'h10000, 24'h0, 1'b0, 5'd2, 16'hFFFF);      // count of two, zero radius
    send_item(OP_TICK, 4'h0, 0, 0, 0, 16'hFFFF);
    send_item(OP_TICK, 4'h0, 0, 0, 0, 16'hFFFF);
  endtask

  task automatic test_random(input int n);
    int cnt;
    while (n > 0) begin
      cnt = $urandom_range(1, 16);
      setup($urandom_range(1) ? 24'($urandom_range(0, 24'h60000)) : 24'($urandom()),
            $urandom_range(3) != 0 ? 24'($urandom_range(0, 24'h80000)) : 24'($urandom()),
            1'($urandom_range(1)), cnt[4:0], 16'($urandom()));
      load_all(16);
      n -= 16;
      send_item(OP_SETPOS, 4'h0, rnd_coord(), rnd_coord(), rnd_coord(), 16'($urandom()));
      repeat (60) begin
        case ($urandom_range(9))
          0: send_item(OP_SETPOS, 4'($urandom()), rnd_coord(), rnd_coord(), rnd_coord(),
                       16'($urandom()));
          1: send_item($urandom_range(1) ? OP_LOAD : OP_NONE, 4'($urandom()), rnd_coord(),
                       rnd_coord(), rnd_coord(), 16'($urandom()));
          default: send_item(OP_TICK, 4'($urandom()), $urandom(), $urandom(), $urandom(),
                             16'($urandom()));
        endcase
        n--;
      end
    end
  endtask

  task automatic test_pause_until_empty();
    send_item(OP_TICK, 4'h0, 0, 0, 0, 16'h800);
    send_item(OP_TICK, 4'h0, 0, 0, 0, 16'h800);
    drain();
    send_item(OP_TICK, 4'h0, 0, 0, 0, 16'h1000);
  endtask

  // result checker and sink stalls
  always @(posedge clk_i) begin
    pose_t got, want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = m_tdata_o[116:0];
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pose_q.pop_front();
        if (got.px !== want.px) $display("%0t: pos_x exp %h got %h", $time, want.px, got.px);
        if (got.py !== want.py) $display("%0t: pos_y exp %h got %h", $time, want.py, got.py);
        if (got.pz !== want.pz) $display("%0t: pos_z exp %h got %h", $time, want.pz, got.pz);
        if (got.hdg !== want.hdg)
          $display("%0t: heading exp %h got %h", $time, want.hdg, got.hdg);
        if (got.idx !== want.idx)
          $display("%0t: target_index exp %h got %h", $time, want.idx, got.idx);
        if (got.hit !== want.hit)
          $display("%0t: reached exp %b got %b", $time, want.hit, got.hit);
        if (got !== want) errors++;
      end
    end
  end

  int sink_hold = 0;
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_tready_i <= 1'b0;
    end else if (idle_on && $urandom_range(7) == 0) begin
      sink_hold <= $urandom_range(1, 15) - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    m_speed = 0; m_accept = 24'h10000; m_flip = 0; m_count = 0; m_interval = 16'd4096;
    m_pos = '{0, 0, 0}; m_yaw = 0; m_delay = 0; m_idx = 0; m_aimed = 0;
    for (int i = 0; i < TBL; i++) wp_tbl[i] = '{0, 0, 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pause_until_empty();
    test_random(1100);
    idle_on = 0;
    test_random(300);
    drain();
    $display("Sent %0d items (%0d ticks), %0d waypoint hits predicted.",
             n_sent, n_ticks, n_hits);
    if (errors == 0 && pose_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/wf_pkg.sv
design/wf_ram.sv
design/wf_cordic.sv
design/waypoint_follower_top.sv
design/wf_checker.sv
tb/tb_top.sv
